### design/hsfr_pkg.sv
// shared types, register indexes and status codes of the slave frame receiver
`timescale 1ns / 1ps

package hsfr_pkg;

  // default for the fewest leading 0xff bytes ahead of an early delimiter
  localparam int unsigned MIN_START_PREAMBLE_DEF = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_ADDRESS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUFACTURER_ID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TYPE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID       = 3'd4;

  // frame status codes
  localparam logic [3:0] ST_OK              = 4'd0;
  localparam logic [3:0] ST_SHORT_PREAMBLE  = 4'd1;
  localparam logic [3:0] ST_EXPANSION       = 4'd2;
  localparam logic [3:0] ST_NOT_STX         = 4'd3;
  localparam logic [3:0] ST_NOT_FSK         = 4'd4;
  localparam logic [3:0] ST_POLL_MISMATCH   = 4'd5;
  localparam logic [3:0] ST_UNIQUE_MISMATCH = 4'd6;
  localparam logic [3:0] ST_TRUNCATED       = 4'd7;
  localparam logic [3:0] ST_BAD_CHECK       = 4'd8;

  // delimiter fields
  localparam logic [7:0] DELIM_EXP_MASK  = 8'h60;
  localparam logic [7:0] DELIM_PHYS_MASK = 8'h18;
  localparam logic [7:0] DELIM_TYPE_MASK = 8'h07;
  localparam logic [7:0] DELIM_TYPE_STX  = 8'h02;
  localparam logic [7:0] ADDR_LOW_MASK   = 8'h3f;
  localparam logic [7:0] PREAMBLE_BYTE   = 8'hff;

  typedef struct packed {
    logic [4:0]  preamble_size;
    logic [5:0]  poll_address;
    logic [5:0]  manufacturer_id;
    logic [7:0]  device_type;
    logic [23:0] device_id;
  } hsfr_cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] command;
    logic [7:0] byte_count;
    logic [3:0] status;
  } hsfr_result_t;

endpackage

### design/hsfr_in_stage.sv
// input register stage for received bytes
`timescale 1ns / 1ps

module hsfr_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  // free when empty or when the held beat moves on this cycle
  assign in_tready = !valid_r || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;
  assign held_last  = last_r;

endmodule

### design/hsfr_parser.sv
// frame parse state and per-byte decode
`timescale 1ns / 1ps

module hsfr_parser #(
  parameter int unsigned MIN_START_PREAMBLE = hsfr_pkg::MIN_START_PREAMBLE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  input  hsfr_pkg::hsfr_cfg_t    cfg,
  output logic                   res_valid,
  output hsfr_pkg::hsfr_result_t res
);

  localparam logic [2:0] PH_PREAMBLE = 3'd0;
  localparam logic [2:0] PH_ADDRESS  = 3'd1;
  localparam logic [2:0] PH_COMMAND  = 3'd2;
  localparam logic [2:0] PH_COUNT    = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;
  localparam logic [2:0] PH_CHECK    = 3'd5;

  localparam logic [5:0] MIN_PRE = 6'(MIN_START_PREAMBLE);
  localparam logic [2:0] LAST_UNIQUE_IDX = 3'd4;
  // index value once all five unique address bytes have been taken
  localparam logic [2:0] ADDR_END_IDX = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [4:0] pre_cnt_r, pre_cnt_nxt;
  logic       unique_r, unique_nxt;
  logic [2:0] addr_idx_r, addr_idx_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       done_r, done_nxt;
  logic       addr_bad_r, addr_bad_nxt;

  logic       fin;
  logic [3:0] fin_status;
  logic       emit;
  logic [5:0] pre_ext;
  logic [7:0] expected;
  logic [7:0] got;
  logic       bad_now;

  assign pre_ext = {1'b0, pre_cnt_r};

  // unique address byte expected at the current index
  always_comb begin
    case (addr_idx_r)
      3'd0:    expected = {2'b00, cfg.manufacturer_id};
      3'd1:    expected = cfg.device_type;
      3'd2:    expected = cfg.device_id[23:16];
      3'd3:    expected = cfg.device_id[15:8];
      default: expected = cfg.device_id[7:0];
    endcase
  end

  // next state and result for the byte in the input register
  always_comb begin
    phase_nxt    = phase_r;
    pre_cnt_nxt  = pre_cnt_r;
    unique_nxt   = unique_r;
    addr_idx_nxt = addr_idx_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    left_nxt     = left_r;
    xor_nxt      = xor_r;
    done_nxt     = done_r;
    addr_bad_nxt = addr_bad_r;
    fin          = 1'b0;
    fin_status   = hsfr_pkg::ST_OK;
    emit         = 1'b0;
    got          = in_byte;
    bad_now      = 1'b0;

    if (!done_r) begin
      case (phase_r)
        PH_PREAMBLE: begin
          if (in_last && (pre_ext + 6'd1 < MIN_PRE)) begin
            fin        = 1'b1;
            fin_status = hsfr_pkg::ST_TRUNCATED;
          end else if (in_byte == hsfr_pkg::PREAMBLE_BYTE &&
                       pre_cnt_r < cfg.preamble_size) begin
            pre_cnt_nxt = pre_cnt_r + 5'd1;
            if (in_last) begin
              fin        = 1'b1;
              fin_status = hsfr_pkg::ST_TRUNCATED;
            end
          end else if (in_byte != hsfr_pkg::PREAMBLE_BYTE &&
                       pre_cnt_r < cfg.preamble_size && pre_ext < MIN_PRE) begin
            fin        = 1'b1;
            fin_status = hsfr_pkg::ST_SHORT_PREAMBLE;
          end else if ((in_byte & hsfr_pkg::DELIM_EXP_MASK) != 8'h00) begin
            fin        = 1'b1;
            fin_status = hsfr_pkg::ST_EXPANSION;
          end else if ((in_byte & hsfr_pkg::DELIM_TYPE_MASK) != hsfr_pkg::DELIM_TYPE_STX) begin
            fin        = 1'b1;
            fin_status = hsfr_pkg::ST_NOT_STX;
          end else if ((in_byte & hsfr_pkg::DELIM_PHYS_MASK) != 8'h00) begin
            fin        = 1'b1;
            fin_status = hsfr_pkg::ST_NOT_FSK;
          end else begin
            unique_nxt   = in_byte[7];
            xor_nxt      = in_byte;
            addr_idx_nxt = 3'd0;
            addr_bad_nxt = 1'b0;
            phase_nxt    = PH_ADDRESS;
            if (in_last) begin
              fin        = 1'b1;
              fin_status = hsfr_pkg::ST_TRUNCATED;
            end
          end
        end

        PH_ADDRESS: begin
          xor_nxt = xor_r ^ in_byte;
          if (unique_r) begin
            got          = (addr_idx_r == 3'd0) ? (in_byte & hsfr_pkg::ADDR_LOW_MASK)
                                                : in_byte;
            bad_now      = (got != expected);
            addr_bad_nxt = addr_bad_r | bad_now;
            addr_idx_nxt = addr_idx_r + 3'd1;
            if (addr_idx_r < LAST_UNIQUE_IDX) begin
              if (in_last) begin
                fin        = 1'b1;
                fin_status = hsfr_pkg::ST_TRUNCATED;
              end
            end else if (addr_bad_nxt) begin
              fin        = 1'b1;
              fin_status = hsfr_pkg::ST_UNIQUE_MISMATCH;
            end else begin
              phase_nxt = PH_COMMAND;
              if (in_last) begin
                fin        = 1'b1;
                fin_status = hsfr_pkg::ST_TRUNCATED;
              end
            end
          end else begin
            bad_now      = ((in_byte & hsfr_pkg::ADDR_LOW_MASK) != {2'b00, cfg.poll_address});
            addr_bad_nxt = addr_bad_r | bad_now;
            if (addr_bad_nxt) begin
              fin        = 1'b1;
              fin_status = hsfr_pkg::ST_POLL_MISMATCH;
            end else begin
              phase_nxt = PH_COMMAND;
              if (in_last) begin
                fin        = 1'b1;
                fin_status = hsfr_pkg::ST_TRUNCATED;
              end
            end
          end
        end

        PH_COMMAND: begin
          xor_nxt   = xor_r ^ in_byte;
          cmd_nxt   = in_byte;
          phase_nxt = PH_COUNT;
          if (in_last) begin
            fin        = 1'b1;
            fin_status = hsfr_pkg::ST_TRUNCATED;
          end
        end

        PH_COUNT: begin
          xor_nxt   = xor_r ^ in_byte;
          cnt_nxt   = in_byte;
          left_nxt  = in_byte;
          phase_nxt = (in_byte != 8'h00) ? PH_DATA : PH_CHECK;
          if (in_last) begin
            fin        = 1'b1;
            fin_status = hsfr_pkg::ST_TRUNCATED;
          end
        end

        PH_DATA: begin
          xor_nxt  = xor_r ^ in_byte;
          left_nxt = left_r - 8'd1;
          if (in_last) begin
            fin        = 1'b1;
            fin_status = hsfr_pkg::ST_TRUNCATED;
          end else begin
            emit = 1'b1;
            if (left_nxt == 8'h00) begin
              phase_nxt = PH_CHECK;
            end
          end
        end

        PH_CHECK: begin
          fin        = 1'b1;
          fin_status = (in_byte == xor_r) ? hsfr_pkg::ST_OK : hsfr_pkg::ST_BAD_CHECK;
        end

        default: begin
          phase_nxt    = PH_PREAMBLE;
          pre_cnt_nxt  = 5'd0;
          unique_nxt   = 1'b0;
          addr_idx_nxt = 3'd0;
          cmd_nxt      = 8'h00;
          cnt_nxt      = 8'h00;
          left_nxt     = 8'h00;
          xor_nxt      = 8'h00;
          addr_bad_nxt = 1'b0;
        end
      endcase
    end

    // a finished frame swallows bytes until the end of the buffer
    if (fin) begin
      done_nxt = 1'b1;
    end

    // result beat, taken before the end-of-buffer restart
    res_valid        = fire && (fin || emit);
    res.kind         = fin;
    res.payload_byte = fin ? 8'h00 : in_byte;
    res.command      = fin ? cmd_nxt : 8'h00;
    res.byte_count   = fin ? cnt_nxt : 8'h00;
    res.status       = fin ? fin_status : hsfr_pkg::ST_OK;

    // end of buffer restarts the frame
    if (in_last) begin
      phase_nxt    = PH_PREAMBLE;
      pre_cnt_nxt  = 5'd0;
      unique_nxt   = 1'b0;
      addr_idx_nxt = 3'd0;
      cmd_nxt      = 8'h00;
      cnt_nxt      = 8'h00;
      left_nxt     = 8'h00;
      xor_nxt      = 8'h00;
      done_nxt     = 1'b0;
      addr_bad_nxt = 1'b0;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_PREAMBLE;
      pre_cnt_r  <= 5'd0;
      unique_r   <= 1'b0;
      addr_idx_r <= 3'd0;
      cmd_r      <= 8'h00;
      cnt_r      <= 8'h00;
      left_r     <= 8'h00;
      xor_r      <= 8'h00;
      done_r     <= 1'b0;
      addr_bad_r <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      pre_cnt_r  <= pre_cnt_nxt;
      unique_r   <= unique_nxt;
      addr_idx_r <= addr_idx_nxt;
      cmd_r      <= cmd_nxt;
      cnt_r      <= cnt_nxt;
      left_r     <= left_nxt;
      xor_r      <= xor_nxt;
      done_r     <= done_nxt;
      addr_bad_r <= addr_bad_nxt;
    end
  end

  // payload beats only come out of the data phase
  a_payload_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.kind |-> phase_r == PH_DATA)
    else $error("payload beat outside data phase");

  // a finished frame stays silent
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && done_r |-> !res_valid)
    else $error("result after frame finished");

  // end of buffer always restarts the parse
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_last |=> !done_r && phase_r == PH_PREAMBLE && pre_cnt_r == 5'd0)
    else $error("no restart after last byte");

  // unique address index stops one past the last address byte
  a_addr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    addr_idx_r <= ADDR_END_IDX)
    else $error("address index out of range");

endmodule

### design/hsfr_out_stage.sv
// result register feeding the output stream
`timescale 1ns / 1ps

module hsfr_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic                   res_valid,
  input  hsfr_pkg::hsfr_result_t res,
  output logic                   free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output hsfr_pkg::hsfr_result_t out_res
);

  logic                   valid_r;
  hsfr_pkg::hsfr_result_t res_r;

  // slot can take a new beat when empty or draining now
  assign free = !valid_r || out_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

### design/hart_slave_frame_receiver.sv
// top level of the slave frame receiver: config registers and stream stages
//
//  channel  dir  tdata (low bit up)                                   side bits
//  in_      in   [7:0] in_byte                                        tlast = last_byte
//  out_     out  [7:0] payload_byte [15:8] command [23:16] byte_count tuser = kind
//                [27:24] status [31:28] zero
//  cfg_     in   cfg_index selects register, cfg_wdata low bits      cfg_we strobe
//
// one byte per cycle sustained while out_ is not stalled; a byte is held in the
// input register and its result in the result register on the way to out_.
// the per-byte parse is a single state update between those two registers.
// reset is synchronous on rst_n and returns config to defaults and the parser
// to the preamble phase. a stalled out_ side holds the input register and then
// in_tready.
`timescale 1ns / 1ps

module hart_slave_frame_receiver #(
  parameter int unsigned MIN_START_PREAMBLE = hsfr_pkg::MIN_START_PREAMBLE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] in_byte
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // payload_byte, command, byte_count, status
  output logic                            out_tuser,  // [0] kind
  input  logic                            cfg_we,
  input  logic [hsfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hsfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  hsfr_pkg::hsfr_cfg_t    cfg_r;
  hsfr_pkg::hsfr_result_t res;
  hsfr_pkg::hsfr_result_t out_res;
  logic                   held_valid;
  logic [7:0]             held_byte;
  logic                   held_last;
  logic                   res_valid;
  logic                   out_free;
  logic                   advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_size   <= 5'd5;
      cfg_r.poll_address    <= 6'd0;
      cfg_r.manufacturer_id <= 6'd0;
      cfg_r.device_type     <= 8'd0;
      cfg_r.device_id       <= 24'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        hsfr_pkg::CFG_PREAMBLE_SIZE:   cfg_r.preamble_size   <= cfg_wdata[4:0];
        hsfr_pkg::CFG_POLL_ADDRESS:    cfg_r.poll_address    <= cfg_wdata[5:0];
        hsfr_pkg::CFG_MANUFACTURER_ID: cfg_r.manufacturer_id <= cfg_wdata[5:0];
        hsfr_pkg::CFG_DEVICE_TYPE:     cfg_r.device_type     <= cfg_wdata[7:0];
        hsfr_pkg::CFG_DEVICE_ID:       cfg_r.device_id       <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // held byte moves on when the result slot is free
  assign advance = held_valid && out_free;

  hsfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  hsfr_parser #(
    .MIN_START_PREAMBLE (MIN_START_PREAMBLE)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .in_byte   (held_byte),
    .in_last   (held_last),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  hsfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res_valid  (res_valid),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // pack the result beat
  assign out_tuser = out_res.kind;
  assign out_tdata = {4'h0, out_res.status, out_res.byte_count,
                      out_res.command, out_res.payload_byte};

endmodule
